/* rtl/core/motor_speed_ramp_pd_controller_defines.svh */
// ----------------------------------------------------------------------------
// Speed loop assertion macros
// Shared property shapes for the motor speed loop checks. Each macro expects
// clk and arst_n in scope and disables the check while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_RAMP_PD_CONTROLLER_DEFINES_SVH
`define MOTOR_SPEED_RAMP_PD_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define MSPD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("speed loop check failed");

// Next-cycle implication.
`define MSPD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("speed loop check failed");

`endif

/* rtl/core/mspd_pkg.sv */
// ----------------------------------------------------------------------------
// Speed loop package
// Widths, command and register codes, and the small fixed-point helpers
// shared by the speed loop and its divider.
// ----------------------------------------------------------------------------
package mspd_pkg;

	// Field widths.
	localparam int CMD_W     = 2;
	localparam int DIST_W    = 16;
	localparam int SPD_W     = 24;
	localparam int DT_W      = 20;
	localparam int DUTY_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;
	localparam int MIN_DRV_W = 9;
	localparam int GAIN_W    = 11;

	// Divider geometry: |distance| * 1e6 needs 35 bits, divisor is the time delta.
	localparam int DIV_N     = 35;
	localparam int DIV_D     = DT_W;
	localparam int DIV_CNT_W = $clog2(DIV_N + 1);

	// Commands.
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DRIVE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_POLARITY  = 3'd6;

	// Scale from Q8.8 distance per microsecond to Q16.8 speed per second.
	localparam logic signed [20:0] DIST_SCALE = 21'sd1000000;

	// Speed limits in Q16.8.
	localparam logic signed [SPD_W-1:0] SPD_MAX = 24'sh7FFFFF;
	localparam logic signed [SPD_W-1:0] SPD_MIN = 24'sh800000;

	// Gain table break points on |drive| in Q16.8 and Q4.12 multipliers.
	localparam logic [SPD_W-1:0] TH_150 = 24'(150 * 256);
	localparam logic [SPD_W-1:0] TH_250 = 24'(250 * 256);
	localparam logic [SPD_W-1:0] TH_350 = 24'(350 * 256);
	localparam logic [SPD_W-1:0] TH_450 = 24'(450 * 256);
	localparam logic [SPD_W-1:0] TH_550 = 24'(550 * 256);
	localparam logic [SPD_W-1:0] TH_650 = 24'(650 * 256);

	// Sign-extend a speed to the common wide working width.
	function automatic logic signed [47:0] sx48(input logic [SPD_W-1:0] v);
		return $signed({{24{v[SPD_W-1]}}, v});
	endfunction

	// Saturate a wide signed value to the Q16.8 speed range.
	function automatic logic signed [SPD_W-1:0] sat_spd(input logic signed [47:0] v);
		if (v > sx48(SPD_MAX)) begin
			return SPD_MAX;
		end else if (v < sx48(SPD_MIN)) begin
			return SPD_MIN;
		end
		return v[SPD_W-1:0];
	endfunction

	// Magnitude of a speed; the most negative value maps to 2^23.
	function automatic logic [SPD_W-1:0] abs_spd(input logic [SPD_W-1:0] v);
		return v[SPD_W-1] ? (24'd0 - v) : v;
	endfunction

	// Piecewise gain on the drive magnitude.
	function automatic logic [GAIN_W-1:0] gain_lookup(input logic [SPD_W-1:0] m);
		if (m <= TH_150) begin
			return 11'd1638;
		end else if (m <= TH_250) begin
			return 11'd860;
		end else if (m <= TH_350) begin
			return 11'd655;
		end else if (m <= TH_450) begin
			return 11'd553;
		end else if (m <= TH_550) begin
			return 11'd492;
		end else if (m <= TH_650) begin
			return 11'd451;
		end
		return 11'd410;
	endfunction

endpackage

/* rtl/core/mspd_div.sv */
// ----------------------------------------------------------------------------
// Speed loop divider
// Unsigned restoring divider, one quotient bit per clock. A start pulse loads
// the operands; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module mspd_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mspd_pkg::DIV_N-1:0]   dividend,
	input  logic [mspd_pkg::DIV_D-1:0]   divisor,
	output logic                         done,
	output logic [mspd_pkg::DIV_N-1:0]   quotient
);
	import mspd_pkg::*;

	logic [DIV_D-1:0]     rem_q;
	logic [DIV_N-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIV_D:0]       trial;
	logic [DIV_D:0]       diff;
	logic                 fits;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, quo_q[DIV_N-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = (trial >= {1'b0, divisor});

	// Iteration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= '0;
				quo_q <= dividend;
				cnt_q <= DIV_CNT_W'(DIV_N);
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= fits ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
				quo_q <= {quo_q[DIV_N-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/core/motor_speed_ramp_pd_controller.sv */
// ----------------------------------------------------------------------------
// Motor speed ramp PD controller
// Speed loop for one motor: ramped target, averaged speed measurement, PD
// correction, piecewise gain and a clamped drive split into duty and direction.
// Input channel: in_valid/in_stall carry one command beat; output channel:
// out_valid/out_stall return one status beat for every command.
// A control tick with a nonzero time delta runs the bit-serial speed divider
// and single steps of a sequencer around one shared multiplier; no new command
// is taken until it is done. Other commands and disabled ticks go straight to
// the final step, and zero-delta ticks pass through the ramp step only.
// The input side takes a new beat whenever the sequencer is idle, even while
// the previous result waits in the output register; a stalled receiver holds
// the finished result in the sequencer until the output register frees up.
// Reset clears the loop state (ramp active, zero speeds and drive, direction
// set) and loads the register defaults; the block is ready right after reset.
// ----------------------------------------------------------------------------
`include "motor_speed_ramp_pd_controller_defines.svh"

module motor_speed_ramp_pd_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration writes.
	input  logic                                 cfg_we,
	input  logic [mspd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mspd_pkg::CFG_W-1:0]           cfg_data,
	// Command channel.
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [mspd_pkg::CMD_W-1:0]           command,
	input  logic signed [mspd_pkg::DIST_W-1:0]   travel_delta,
	input  logic signed [mspd_pkg::SPD_W-1:0]    angle_correction,
	input  logic signed [mspd_pkg::SPD_W-1:0]    position_correction,
	input  logic [mspd_pkg::DT_W-1:0]            time_delta_us,
	input  logic signed [mspd_pkg::SPD_W-1:0]    speed_value,
	// Status channel.
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [mspd_pkg::DUTY_W-1:0]          drive_duty,
	output logic                                 direction_bit,
	output logic signed [mspd_pkg::SPD_W-1:0]    measured_speed,
	output logic signed [mspd_pkg::SPD_W-1:0]    ramp_speed
);
	import mspd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RAMP,
		S_MUL_DIST,
		S_DIV_START,
		S_DIV_WAIT,
		S_TGT,
		S_ERR,
		S_DERR,
		S_MUL_KP,
		S_MUL_KD,
		S_PD,
		S_PMAG,
		S_MUL_GAIN,
		S_DRIVE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              dir;
		logic [DUTY_W-1:0] duty;
	} drive_t;

	// Clamp a signed drive and split it into direction and duty.
	function automatic drive_t drive_out(
		input logic signed [13:0]          d,
		input logic signed [MIN_DRV_W-1:0] mn,
		input logic [DUTY_W-1:0]           mx,
		input logic                        pol
	);
		logic signed [13:0] mn_x;
		logic signed [13:0] mx_x;
		logic signed [13:0] c;
		logic [13:0]        m;
		drive_t             r;
		mn_x = $signed({{5{mn[MIN_DRV_W-1]}}, mn});
		mx_x = $signed({6'b0, mx});
		c = d;
		if (d < mn_x) begin
			c = mn_x;
		end else if (d > mx_x) begin
			c = mx_x;
		end
		if (c[13]) begin
			m      = 14'd0 - c;
			r.dir  = pol;
			r.duty = (m > 14'd255) ? 8'hFF : m[7:0];
		end else begin
			m      = c;
			r.dir  = ~pol;
			r.duty = (m > 14'd255) ? 8'hFF : m[7:0];
		end
		return r;
	endfunction

	// Configuration registers.
	logic                        enable_q;
	logic [CFG_W-1:0]            kp_q;
	logic [CFG_W-1:0]            kd_q;
	logic signed [MIN_DRV_W-1:0] min_drive_q;
	logic [DUTY_W-1:0]           max_drive_q;
	logic [CFG_W-1:0]            ramp_step_q;
	logic                        polarity_q;

	// Sequencer and loop state.
	state_t                      state_q;
	logic signed [SPD_W-1:0]     target_q;
	logic signed [SPD_W-1:0]     ramped_q;
	logic                        ramping_q;
	logic signed [SPD_W-1:0]     prev_err_q;
	logic signed [SPD_W-1:0]     avg_q;
	logic signed [SPD_W-1:0]     prev_raw_q;
	logic [DUTY_W-1:0]           duty_q;
	logic                        dir_q;

	// Latched tick operands and intermediate results.
	logic signed [DIST_W-1:0]    dist_q;
	logic signed [SPD_W-1:0]     ac_q;
	logic signed [SPD_W-1:0]     pc_q;
	logic [DT_W-1:0]             dt_q;
	logic signed [45:0]          prod_q;
	logic signed [45:0]          acc_q;
	logic signed [SPD_W-1:0]     t_q;
	logic signed [SPD_W-1:0]     e_q;
	logic signed [SPD_W-1:0]     de_q;
	logic signed [SPD_W-1:0]     pd_q;
	logic [SPD_W-1:0]            mag_q;
	logic                        p_neg_q;

	// Output register.
	logic                        out_valid_q;
	logic [DUTY_W-1:0]           out_duty_q;
	logic                        out_dir_q;
	logic signed [SPD_W-1:0]     out_meas_q;
	logic signed [SPD_W-1:0]     out_ramp_q;

	// Combinational datapath.
	logic                        in_accept;
	logic signed [24:0]          mul_a;
	logic signed [20:0]          mul_b;
	logic signed [45:0]          mul_p;
	logic [16:0]                 dist_mag;
	logic                        div_start;
	logic                        div_done;
	logic [DIV_N-1:0]            div_quo;
	logic [SPD_W-1:0]            ramped_abs;
	logic [SPD_W-1:0]            target_abs;
	logic                        ramp_reached;
	logic signed [SPD_W-1:0]     ramp_up;
	logic signed [SPD_W-1:0]     ramp_dn;
	logic signed [SPD_W-1:0]     ramp_next;
	logic signed [SPD_W-1:0]     raw_val;
	logic signed [24:0]          avg_sum;
	logic signed [24:0]          avg_adj;
	logic signed [SPD_W-1:0]     avg_val;
	logic signed [SPD_W-1:0]     t_val;
	logic signed [SPD_W-1:0]     e_val;
	logic signed [SPD_W-1:0]     de_val;
	logic signed [47:0]          pd_sum;
	logic signed [47:0]          pd_adj;
	logic signed [47:0]          pd_shift;
	logic signed [SPD_W-1:0]     pd_val;
	logic signed [SPD_W-1:0]     p_val;
	logic [12:0]                 gain_q13;
	logic [13:0]                 drive_mag;
	logic signed [13:0]          drive_val;
	drive_t                      tick_drive;
	drive_t                      reset_drive;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;

	// Configuration write decode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			kp_q        <= 16'd4096;
			kd_q        <= 16'd0;
			min_drive_q <= -9'sd255;
			max_drive_q <= 8'd255;
			ramp_step_q <= 16'd2048;
			polarity_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:    enable_q    <= cfg_data[0];
				REG_KP:        kp_q        <= cfg_data;
				REG_KD:        kd_q        <= cfg_data;
				REG_MIN_DRIVE: min_drive_q <= cfg_data[MIN_DRV_W-1:0];
				REG_MAX_DRIVE: max_drive_q <= cfg_data[DUTY_W-1:0];
				REG_RAMP_STEP: ramp_step_q <= cfg_data;
				REG_POLARITY:  polarity_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Shared multiplier: operands picked by the sequencer step.
	assign dist_mag = dist_q[DIST_W-1] ? (17'd0 - {1'b1, dist_q}) : {1'b0, dist_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL_DIST: begin
				mul_a = $signed({8'b0, dist_mag});
				mul_b = DIST_SCALE;
			end
			S_MUL_KP: begin
				mul_a = $signed({e_q[SPD_W-1], e_q});
				mul_b = $signed({5'b0, kp_q});
			end
			S_MUL_KD: begin
				mul_a = $signed({de_q[SPD_W-1], de_q});
				mul_b = $signed({5'b0, kd_q});
			end
			S_MUL_GAIN: begin
				mul_a = $signed({1'b0, mag_q});
				mul_b = $signed({10'b0, gain_lookup(mag_q)});
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Speed divider: scaled distance over the time delta.
	assign div_start = (state_q == S_DIV_START);

	mspd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q[DIV_N-1:0]),
		.divisor  (dt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Ramp step toward the target.
	assign ramped_abs   = abs_spd(ramped_q);
	assign target_abs   = abs_spd(target_q);
	assign ramp_reached = (ramped_abs >= target_abs);
	assign ramp_up      = sat_spd(sx48(ramped_q) + {32'b0, ramp_step_q});
	assign ramp_dn      = sat_spd(sx48(ramped_q) - {32'b0, ramp_step_q});

	always_comb begin
		if (!ramping_q || ramp_reached) begin
			ramp_next = target_q;
		end else if (target_q[SPD_W-1]) begin
			ramp_next = ramp_dn;
		end else begin
			ramp_next = ramp_up;
		end
	end

	// Raw speed with sign and saturation, then the two-sample average.
	always_comb begin
		if (dist_q[DIST_W-1]) begin
			raw_val = (div_quo > 35'd8388608) ? SPD_MIN : (24'd0 - div_quo[SPD_W-1:0]);
		end else begin
			raw_val = (div_quo > 35'd8388607) ? SPD_MAX : div_quo[SPD_W-1:0];
		end
	end

	assign avg_sum = {raw_val[SPD_W-1], raw_val} + {prev_raw_q[SPD_W-1], prev_raw_q};
	assign avg_adj = avg_sum + {24'b0, avg_sum[24]};
	assign avg_val = avg_adj[24:1];

	// Target, error and error change.
	assign t_val  = sat_spd(sx48(ramped_q) + sx48(ac_q) + sx48(pc_q));
	assign e_val  = sat_spd(sx48(t_q) - sx48(avg_q));
	assign de_val = sat_spd(sx48(e_q) - sx48(prev_err_q));

	// PD term: sum of products divided by 4096, truncated toward zero.
	assign pd_sum   = {{2{acc_q[45]}}, acc_q} + {{2{prod_q[45]}}, prod_q};
	assign pd_adj   = pd_sum + (pd_sum[47] ? 48'sd4095 : 48'sd0);
	assign pd_shift = pd_adj >>> 12;
	assign pd_val   = sat_spd(pd_shift);
	assign p_val    = sat_spd(sx48(t_q) + sx48(pd_q));

	// Scaled magnitude, capped, with the drive sign restored.
	assign gain_q13   = (prod_q[45:20] > 26'd4096) ? 13'd4096 : prod_q[32:20];
	assign drive_mag  = {1'b0, gain_q13};
	assign drive_val  = p_neg_q ? $signed(14'd0 - drive_mag) : $signed(drive_mag);
	assign tick_drive = drive_out(drive_val, min_drive_q, max_drive_q, polarity_q);
	assign reset_drive = drive_out(14'sd0, min_drive_q, max_drive_q, polarity_q);

	// Sequencer, loop state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			target_q    <= '0;
			ramped_q    <= '0;
			ramping_q   <= 1'b1;
			prev_err_q  <= '0;
			avg_q       <= '0;
			prev_raw_q  <= '0;
			duty_q      <= '0;
			dir_q       <= 1'b1;
			dist_q      <= '0;
			ac_q        <= '0;
			pc_q        <= '0;
			dt_q        <= '0;
			prod_q      <= '0;
			acc_q       <= '0;
			t_q         <= '0;
			e_q         <= '0;
			de_q        <= '0;
			pd_q        <= '0;
			mag_q       <= '0;
			p_neg_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_duty_q  <= '0;
			out_dir_q   <= 1'b0;
			out_meas_q  <= '0;
			out_ramp_q  <= '0;
		end else begin
			prod_q <= mul_p;
			// The final step refills the output register itself.
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						dist_q  <= travel_delta;
						ac_q    <= angle_correction;
						pc_q    <= position_correction;
						dt_q    <= time_delta_us;
						unique case (command)
							CMD_TICK: begin
								// A disabled tick reports the unchanged state.
								if (enable_q) begin
									state_q <= S_RAMP;
								end else begin
									state_q <= S_DONE;
								end
							end
							CMD_SET: begin
								target_q <= speed_value;
								if (ramped_q != speed_value) begin
									prev_err_q <= '0;
								end
								state_q <= S_DONE;
							end
							CMD_RESET: begin
								ramping_q  <= 1'b1;
								ramped_q   <= '0;
								prev_err_q <= '0;
								duty_q     <= reset_drive.duty;
								dir_q      <= reset_drive.dir;
								state_q    <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_RAMP: begin
					ramped_q <= ramp_next;
					if (ramping_q && ramp_reached) begin
						ramping_q <= 1'b0;
					end
					state_q <= (dt_q == '0) ? S_DONE : S_MUL_DIST;
				end
				S_MUL_DIST: begin
					state_q <= S_DIV_START;
				end
				S_DIV_START: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						avg_q      <= avg_val;
						prev_raw_q <= raw_val;
						state_q    <= S_TGT;
					end
				end
				S_TGT: begin
					t_q     <= t_val;
					state_q <= S_ERR;
				end
				S_ERR: begin
					e_q     <= e_val;
					state_q <= S_DERR;
				end
				S_DERR: begin
					de_q       <= de_val;
					prev_err_q <= e_q;
					state_q    <= S_MUL_KP;
				end
				S_MUL_KP: begin
					state_q <= S_MUL_KD;
				end
				S_MUL_KD: begin
					acc_q   <= prod_q;
					state_q <= S_PD;
				end
				S_PD: begin
					pd_q    <= pd_val;
					state_q <= S_PMAG;
				end
				S_PMAG: begin
					mag_q   <= abs_spd(p_val);
					p_neg_q <= p_val[SPD_W-1];
					state_q <= S_MUL_GAIN;
				end
				S_MUL_GAIN: begin
					state_q <= S_DRIVE;
				end
				S_DRIVE: begin
					duty_q  <= tick_drive.duty;
					dir_q   <= tick_drive.dir;
					state_q <= S_DONE;
				end
				S_DONE: begin
					// Hand the status beat over once the output register is free.
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_duty_q  <= duty_q;
						out_dir_q   <= dir_q;
						out_meas_q  <= avg_q;
						out_ramp_q  <= ramped_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign drive_duty     = out_duty_q;
	assign direction_bit  = out_dir_q;
	assign measured_speed = out_meas_q;
	assign ramp_speed     = out_ramp_q;

	// The divider only reports a quotient while the sequencer waits for it.
	`MSPD_ASSERT_IMP(a_div_done_in_wait, div_done, state_q == S_DIV_WAIT)
	// An accepted command always moves the sequencer out of idle.
	`MSPD_ASSERT_NXT(a_accept_leaves_idle, in_accept, state_q != S_IDLE)
	// A status beat is only raised from the final sequencer step.
	`MSPD_ASSERT_IMP(a_out_from_done, $rose(out_valid_q), $past(state_q) == S_DONE)

endmodule
